@@ sv/ffac_pkg.sv @@
package ffac_pkg;

    localparam int unsigned DW   = 64;
    localparam int unsigned MW   = 53;
    localparam int unsigned EW   = 14;
    localparam int unsigned CIW  = 2;

    localparam logic [CIW-1:0] CFG_MAX_ABS = 2'd0;
    localparam logic [CIW-1:0] CFG_MAX_REL = 2'd1;
    localparam logic [CIW-1:0] CFG_COMPLEX = 2'd2;

    typedef struct packed {
        logic [DW-1:0] a_re;
        logic [DW-1:0] a_im;
        logic [DW-1:0] b_re;
        logic [DW-1:0] b_im;
        logic          last;
    } t_in;

    typedef struct packed {
        logic element_match;
        logic all_match;
        logic last_out;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_CHECK,
        S_ALIGN,
        S_NORM,
        S_ROUND,
        S_DNORM,
        S_DPREP,
        S_DIV,
        S_QROUND,
        S_PART
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_ALIGN,
        OP_NORM,
        OP_ROUND,
        OP_DNORM,
        OP_DPREP,
        OP_DIV
    } t_op;

    typedef struct packed {
        t_op  op;
        logic part;
    } t_cmd;

    typedef struct packed {
        logic nan;
        logic eq;
        logic inf;
        logic norm_done;
        logic abs_ok;
        logic diff_inf;
        logic dnorm_done;
        logic div_last;
        logic rel_ok;
    } t_stat;

endpackage

@@ sv/ffac_dp.sv @@
module ffac_dp (
    input  logic               i_clk,
    input  ffac_pkg::t_cmd     i_cmd,
    input  ffac_pkg::t_in      i_item,
    input  logic [63:0]        i_max_abs,
    input  logic [63:0]        i_max_rel,
    output ffac_pkg::t_stat    o_stat
);

    logic [63:0]        r_x, r_y;
    logic [56:0]        r_acc;
    logic signed [13:0] r_exp, r_ed;
    logic [53:0]        r_rem;
    logic [52:0]        r_md;
    logic [53:0]        r_q;
    logic [5:0]         r_cnt;

    function automatic logic [52:0] mant(input logic [63:0] b);
        mant = {|b[62:52], b[51:0]};
    endfunction

    function automatic logic [10:0] bexp(input logic [63:0] b);
        bexp = (b[62:52] == 11'd0) ? 11'd1 : b[62:52];
    endfunction

    function automatic logic is_nan(input logic [63:0] b);
        is_nan = (&b[62:52]) && (|b[51:0]);
    endfunction

    // round to nearest even, pack into magnitude bits
    function automatic logic [62:0] rnd(input logic [52:0] m, input logic g, input logic s,
                                        input logic signed [13:0] e);
        logic [53:0]        sum;
        logic [52:0]        mo;
        logic signed [13:0] eo;
        sum = {1'b0, m} + {53'd0, g & (s | m[0])};
        if (sum[53]) begin
            mo = sum[53:1];
            eo = e + 14'sd1;
        end else begin
            mo = sum[52:0];
            eo = e;
        end
        if (eo >= 14'sd2047) begin
            rnd = {11'h7FF, 52'd0};
        end else begin
            rnd = {(mo[52] ? eo[10:0] : 11'd0), mo[51:0]};
        end
    endfunction

    function automatic logic tol_gt(input logic [63:0] t, input logic [62:0] r);
        tol_gt = !t[63] && !is_nan(t) && (t[62:0] > r);
    endfunction

    // alignment of the smaller operand
    logic          x_gt, eff_sub;
    logic [63:0]   bb, sb;
    logic [10:0]   sh_full;
    logic [5:0]    sh;
    logic [111:0]  wide;
    logic [56:0]   small57, big57, sum57;

    always_comb begin
        x_gt    = r_x[62:0] > r_y[62:0];
        bb      = x_gt ? r_x : r_y;
        sb      = x_gt ? r_y : r_x;
        eff_sub = r_x[63] == r_y[63];
        sh_full = bexp(bb) - bexp(sb);
        sh      = (sh_full > 11'd63) ? 6'd63 : sh_full[5:0];
        wide    = {mant(sb), 3'b000, 56'd0} >> sh;
        small57 = {1'b0, wide[111:57], wide[56] | (|wide[55:0])};
        big57   = {1'b0, mant(bb), 3'b000};
        sum57   = eff_sub ? (big57 - small57) : (big57 + small57);
    end

    // rounded difference
    logic [62:0] dbits;
    assign dbits = rnd(r_acc[55:3], r_acc[2], |r_acc[1:0], r_exp);

    // quotient denormalise and round
    logic signed [13:0] dd;
    logic [5:0]         dsh;
    logic [117:0]       wq;
    logic [53:0]        qs;
    logic               qst;
    logic signed [13:0] qe;
    logic [62:0]        qbits;

    always_comb begin
        dd  = 14'sd1 - r_exp;
        dsh = 6'd0;
        qe  = r_exp;
        if (r_exp < 14'sd1) begin
            dsh = (dd > 14'sd63) ? 6'd63 : dd[5:0];
            qe  = 14'sd1;
        end
        wq    = {r_q, 64'd0} >> dsh;
        qs    = wq[117:64];
        qst   = (|wq[63:0]) | (|r_rem);
        qbits = rnd(qs[53:1], qs[0], qst, qe);
    end

    logic        ge;
    logic [53:0] rsub;
    assign ge   = r_rem >= {1'b0, r_md};
    assign rsub = ge ? (r_rem - {1'b0, r_md}) : r_rem;

    always_comb begin
        o_stat.nan        = is_nan(r_x) || is_nan(r_y);
        o_stat.eq         = (r_x == r_y) || ((r_x[62:0] == 63'd0) && (r_y[62:0] == 63'd0));
        o_stat.inf        = (&r_x[62:52]) || (&r_y[62:52]);
        o_stat.norm_done  = !r_acc[56] && (r_acc[55] || (r_exp <= 14'sd1));
        o_stat.abs_ok     = tol_gt(i_max_abs, dbits);
        o_stat.diff_inf   = &dbits[62:52];
        o_stat.dnorm_done = r_rem[52] && r_md[52];
        o_stat.div_last   = r_cnt == 6'd1;
        o_stat.rel_ok     = tol_gt(i_max_rel, qbits);
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            ffac_pkg::OP_LOAD: begin
                r_x <= i_cmd.part ? i_item.a_im : i_item.a_re;
                r_y <= i_cmd.part ? i_item.b_im : i_item.b_re;
            end
            ffac_pkg::OP_ALIGN: begin
                r_acc <= sum57;
                r_exp <= $signed({3'b000, bexp(bb)});
                r_ed  <= $signed({3'b000, bexp(bb)});
                r_md  <= mant(bb);
            end
            ffac_pkg::OP_NORM: begin
                priority if (r_acc[56]) begin
                    r_acc <= {1'b0, r_acc[56:2], r_acc[1] | r_acc[0]};
                    r_exp <= r_exp + 14'sd1;
                end else if (!r_acc[55] && (r_exp > 14'sd1)) begin
                    r_acc <= {r_acc[55:0], 1'b0};
                    r_exp <= r_exp - 14'sd1;
                end else begin
                end
            end
            ffac_pkg::OP_ROUND: begin
                r_rem <= {1'b0, |dbits[62:52], dbits[51:0]};
                r_exp <= (dbits[62:52] == 11'd0) ? 14'sd1 : $signed({3'b000, dbits[62:52]});
            end
            ffac_pkg::OP_DNORM: begin
                if (!r_rem[52]) begin
                    r_rem <= {r_rem[52:0], 1'b0};
                    r_exp <= r_exp - 14'sd1;
                end
                if (!r_md[52]) begin
                    r_md <= {r_md[51:0], 1'b0};
                    r_ed <= r_ed - 14'sd1;
                end
            end
            ffac_pkg::OP_DPREP: begin
                r_q   <= 54'd0;
                r_cnt <= 6'd54;
                if (r_rem[52:0] < r_md) begin
                    r_rem <= {r_rem[52:0], 1'b0};
                    r_exp <= r_exp - r_ed + 14'sd1022;
                end else begin
                    r_exp <= r_exp - r_ed + 14'sd1023;
                end
            end
            ffac_pkg::OP_DIV: begin
                r_q   <= {r_q[52:0], ge};
                r_rem <= {rsub[52:0], 1'b0};
                r_cnt <= r_cnt - 6'd1;
            end
            default: begin
            end
        endcase
    end

endmodule

@@ sv/ffac_ctrl.sv @@
module ffac_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_last,
    input  logic            i_complex,
    input  ffac_pkg::t_stat i_stat,
    output ffac_pkg::t_cmd  o_cmd,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output ffac_pkg::t_out  o_out
);

    ffac_pkg::t_state r_state, n_state;
    logic             r_part, n_part;
    logic             r_res, n_res;
    logic             r_run;
    logic             r_out_valid;
    ffac_pkg::t_out   r_out;
    logic             fin;

    always_comb begin
        n_state = r_state;
        n_part  = r_part;
        n_res   = r_res;
        unique case (r_state)
            ffac_pkg::S_IDLE: begin
                n_part = 1'b0;
                if (i_in_valid) n_state = ffac_pkg::S_LOAD;
            end
            ffac_pkg::S_LOAD:  n_state = ffac_pkg::S_CHECK;
            ffac_pkg::S_CHECK: begin
                priority if (i_stat.nan) begin
                    n_res = 1'b0; n_state = ffac_pkg::S_PART;
                end else if (i_stat.eq) begin
                    n_res = 1'b1; n_state = ffac_pkg::S_PART;
                end else if (i_stat.inf) begin
                    n_res = 1'b0; n_state = ffac_pkg::S_PART;
                end else begin
                    n_state = ffac_pkg::S_ALIGN;
                end
            end
            ffac_pkg::S_ALIGN: n_state = ffac_pkg::S_NORM;
            ffac_pkg::S_NORM: begin
                if (i_stat.norm_done) n_state = ffac_pkg::S_ROUND;
            end
            ffac_pkg::S_ROUND: begin
                priority if (i_stat.abs_ok) begin
                    n_res = 1'b1; n_state = ffac_pkg::S_PART;
                end else if (i_stat.diff_inf) begin
                    n_res = 1'b0; n_state = ffac_pkg::S_PART;
                end else begin
                    n_state = ffac_pkg::S_DNORM;
                end
            end
            ffac_pkg::S_DNORM: begin
                if (i_stat.dnorm_done) n_state = ffac_pkg::S_DPREP;
            end
            ffac_pkg::S_DPREP: n_state = ffac_pkg::S_DIV;
            ffac_pkg::S_DIV: begin
                if (i_stat.div_last) n_state = ffac_pkg::S_QROUND;
            end
            ffac_pkg::S_QROUND: begin
                n_res   = i_stat.rel_ok;
                n_state = ffac_pkg::S_PART;
            end
            ffac_pkg::S_PART: begin
                priority if (r_res && i_complex && !r_part) begin
                    n_part  = 1'b1;
                    n_state = ffac_pkg::S_LOAD;
                end else if (!r_out_valid || i_out_ready) begin
                    n_state = ffac_pkg::S_IDLE;
                end else begin
                end
            end
            default: n_state = ffac_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.part = r_part;
        o_in_ready = r_state == ffac_pkg::S_IDLE;
        fin        = (r_state == ffac_pkg::S_PART) && !(r_res && i_complex && !r_part)
                     && (!r_out_valid || i_out_ready);
        unique case (r_state)
            ffac_pkg::S_LOAD:  o_cmd.op = ffac_pkg::OP_LOAD;
            ffac_pkg::S_ALIGN: o_cmd.op = ffac_pkg::OP_ALIGN;
            ffac_pkg::S_NORM:  o_cmd.op = ffac_pkg::OP_NORM;
            ffac_pkg::S_ROUND: o_cmd.op = ffac_pkg::OP_ROUND;
            ffac_pkg::S_DNORM: o_cmd.op = ffac_pkg::OP_DNORM;
            ffac_pkg::S_DPREP: o_cmd.op = ffac_pkg::OP_DPREP;
            ffac_pkg::S_DIV:   o_cmd.op = ffac_pkg::OP_DIV;
            default:           o_cmd.op = ffac_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ffac_pkg::S_IDLE;
            r_part      <= 1'b0;
            r_res       <= 1'b0;
            r_run       <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_part  <= n_part;
            r_res   <= n_res;
            if (fin) begin
                r_out_valid <= 1'b1;
                r_run       <= i_last ? 1'b1 : (r_run & r_res);
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin) begin
            r_out.element_match <= r_res;
            r_out.all_match     <= r_run & r_res;
            r_out.last_out      <= i_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

@@ sv/fuzzy_float_array_compare_top.sv @@
// Approximate equality of two streams of IEEE double values.
// Input channel (i_in_valid / o_in_ready) takes one element pair per
// transfer: real parts, imaginary parts and a last flag. Output channel
// (o_out_valid / i_out_ready) gives one result per pair: the element
// verdict, the running AND over the array, and the copied last flag.
// Configuration is a plain write port: index 0 absolute tolerance,
// index 1 relative tolerance, index 2 complex mode; other indexes drop.
// Each part runs on one shared double-precision unit under a sequencer:
// operand check, one alignment add, a one-bit-per-cycle normalise loop,
// rounding, a one-bit-per-cycle operand normalise for the divide and a
// 54-step restoring divide. A part is decided by the operand check, by the
// absolute test, or else by the relative test on the rounded quotient.
// Complex mode runs the imaginary part only after the real part matched.
// One item is in flight at a time; o_in_ready is high while idle.
// The result sits in an output register; a stalled receiver holds the
// finished next result in the sequencer until the register frees.
// Reset clears tolerances and mode to zero and sets the running AND to one.
module fuzzy_float_array_compare_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  ffac_pkg::t_in   i_in,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output ffac_pkg::t_out  o_out,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_idx,
    input  logic [63:0]     i_cfg_data
);

    logic [63:0]     r_max_abs, r_max_rel;
    logic            r_complex;
    ffac_pkg::t_in   r_item;
    ffac_pkg::t_cmd  cmd;
    ffac_pkg::t_stat stat;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_abs <= 64'd0;
            r_max_rel <= 64'd0;
            r_complex <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ffac_pkg::CFG_MAX_ABS: r_max_abs <= i_cfg_data;
                ffac_pkg::CFG_MAX_REL: r_max_rel <= i_cfg_data;
                ffac_pkg::CFG_COMPLEX: r_complex <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // hold the accepted pair for the whole comparison
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= i_in;
        end
    end

    ffac_dp u_dp (
        .i_clk     (i_clk),
        .i_cmd     (cmd),
        .i_item    (r_item),
        .i_max_abs (r_max_abs),
        .i_max_rel (r_max_rel),
        .o_stat    (stat)
    );

    ffac_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_last      (r_item.last),
        .i_complex   (r_complex),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

@@ dv/tb.sv @@
module tb;
    import ffac_pkg::*;

    localparam logic [63:0] MAG_MASK  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] EXP_BITS  = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] FRAC_BITS = 64'h000F_FFFF_FFFF_FFFF;
    localparam logic [63:0] POS_INF   = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] NEG_INF   = 64'hFFF0_0000_0000_0000;
    localparam logic [63:0] QNAN      = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0] NEG_ZERO  = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ONE       = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] TWO       = 64'h4000_0000_0000_0000;
    localparam logic [63:0] MAX_FIN   = 64'h7FEF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MIN_DEN   = 64'h0000_0000_0000_0001;
    localparam int unsigned SETTLE    = 400;
    localparam int unsigned WDOG_MAX  = 40000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in         i_in = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out        o_out;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [63:0] i_cfg_data = '0;

    // local copy of the block's registers and running AND
    logic [63:0] abs_tol, rel_tol;
    logic        cplx, run_and;

    t_out        verdicts[$];
    int unsigned n_bad, n_sent, n_seen, n_last, n_hits, wdog;
    int unsigned gap_pct, stall_pct;

    fuzzy_float_array_compare_top dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic bit is_nan(logic [63:0] v);
        return ((v & EXP_BITS) == EXP_BITS) && ((v & FRAC_BITS) != 0);
    endfunction

    // strict greater-than on double bits; any NaN operand gives false
    function automatic bit tol_above(logic [63:0] tol, logic [63:0] v);
        if (is_nan(tol) || is_nan(v))
            return 1'b0;
        return $bitstoreal(tol) > $bitstoreal(v);
    endfunction

    function automatic bit part_close(logic [63:0] x, logic [63:0] y);
        real xr, yr, d, q, dv;
        if (is_nan(x) || is_nan(y))
            return 1'b0;
        xr = $bitstoreal(x);
        yr = $bitstoreal(y);
        if (xr == yr)
            return 1'b1;
        d = xr - yr;
        if (tol_above(abs_tol, $realtobits(d) & MAG_MASK))
            return 1'b1;
        // larger magnitude divides, b on a tie; neither is NaN here
        dv = ((x & MAG_MASK) > (y & MAG_MASK)) ? xr : yr;
        q = d / dv;
        return tol_above(rel_tol, $realtobits(q) & MAG_MASK);
    endfunction

    function automatic t_out predict_verdict(t_in it);
        t_out r;
        logic m;
        m = part_close(it.a_re, it.b_re);
        if (cplx && m)
            m = part_close(it.a_im, it.b_im);
        run_and = run_and & m;
        r.element_match = m;
        r.all_match = run_and;
        r.last_out = it.last;
        if (it.last)
            run_and = 1'b1;
        return r;
    endfunction

    task automatic report(string what, t_out got, t_out want);
        n_bad++;
        $display("mismatch %s: got %b%b%b want %b%b%b (result %0d)", what,
                 got.element_match, got.all_match, got.last_out,
                 want.element_match, want.all_match, want.last_out, n_seen);
    endtask

    // receiver side: stall at random, check each transfer against the oldest verdict
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
        if (i_in_valid && o_in_ready || o_out_valid && i_out_ready)
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_seen++;
            if (verdicts.size() == 0) begin
                report("unexpected", o_out, '0);
            end else begin
                if (o_out.element_match !== verdicts[0].element_match)
                    report("element_match", o_out, verdicts[0]);
                if (o_out.all_match !== verdicts[0].all_match)
                    report("all_match", o_out, verdicts[0]);
                if (o_out.last_out !== verdicts[0].last_out)
                    report("last_out", o_out, verdicts[0]);
                if (o_out.element_match === 1'b1)
                    n_hits++;
                void'(verdicts.pop_front());
            end
        end
        if (wdog >= WDOG_MAX) begin
            $display("watchdog expired, %0d results outstanding", verdicts.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_item(t_in it);
        if ($urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= it;
        do @(posedge i_clk); while (!o_in_ready);
        verdicts.push_back(predict_verdict(it));
        n_sent++;
        if (it.last)
            n_last++;
    endtask

    // hold until every verdict is back, then let the sequencer drain
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (verdicts.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [63:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_MAX_ABS)
            abs_tol = val;
        else if (idx == CFG_MAX_REL)
            rel_tol = val;
        else if (idx == CFG_COMPLEX)
            cplx = val[0];
    endtask

    function automatic logic [63:0] pick_value();
        logic [63:0] v;
        case ($urandom_range(0, 11))
            0: v = POS_INF;
            1: v = NEG_INF;
            2: v = {$urandom_range(0, 1) ? 1'b1 : 1'b0, 11'h7FF, 20'($urandom | 1), 32'($urandom)};
            3: v = {$urandom_range(0, 1) ? 1'b1 : 1'b0, 63'd0};
            4: v = {1'($urandom), 11'd0, 20'($urandom), 32'($urandom)};
            5: v = {$urandom, $urandom};
            6: v = MAX_FIN | {1'($urandom), 63'd0};
            default: v = {1'($urandom), 11'($urandom_range(1003, 1043)),
                          20'($urandom), 32'($urandom)};
        endcase
        return v;
    endfunction

    function automatic logic [63:0] near_value(logic [63:0] a);
        case ($urandom_range(0, 6))
            0: return a;
            1: return a ^ NEG_ZERO;
            2: return a + 64'($urandom_range(1, 4000));
            3: return a - 64'($urandom_range(1, 4000));
            4: return a ^ (64'd1 << $urandom_range(0, 63));
            5: return a + (64'd1 << $urandom_range(30, 52));
            default: return pick_value();
        endcase
    endfunction

    function automatic t_in make_pair(int unsigned last_pct);
        t_in it;
        it.a_re = pick_value();
        it.b_re = near_value(it.a_re);
        it.a_im = pick_value();
        it.b_im = near_value(it.a_im);
        it.last = ($urandom_range(0, 99) < last_pct);
        return it;
    endfunction

    function automatic t_in pair(logic [63:0] ar, logic [63:0] br,
                                 logic [63:0] ai, logic [63:0] bi, logic lst);
        t_in it;
        it.a_re = ar; it.b_re = br; it.a_im = ai; it.b_im = bi; it.last = lst;
        return it;
    endfunction

    function automatic logic [63:0] pick_abs();
        case ($urandom_range(0, 5))
            0: return 64'd0;
            1: return 64'h3E11_2E0B_E826_D695;      // 1e-9
            2: return ONE;
            3: return POS_INF;
            4: return QNAN;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [63:0] pick_rel();
        case ($urandom_range(0, 5))
            0: return 64'd0;
            1: return 64'h3D71_9799_812D_EA11;      // 1e-12
            2: return 64'h3EB0_C6F7_A0B5_ED8D;      // 1e-6
            3: return 64'h3FE0_0000_0000_0000;      // 0.5
            4: return 64'hFFFF_FFFF_FFFF_FFFF;
            default: return POS_INF;
        endcase
    endfunction

    // special operand cases with tolerances at zero, then at the top
    task automatic test_special_operands();
        gap_pct = 0; stall_pct = 0;
        cfg_write(CFG_MAX_ABS, 64'd0);
        cfg_write(CFG_MAX_REL, 64'd0);
        cfg_write(CFG_COMPLEX, 64'd0);
        send_item(pair(QNAN, QNAN, 0, 0, 1'b0));
        send_item(pair(ONE, ONE, 0, 0, 1'b1));
        send_item(pair(64'd0, NEG_ZERO, 0, 0, 1'b0));
        send_item(pair(POS_INF, POS_INF, 0, 0, 1'b0));
        send_item(pair(POS_INF, NEG_INF, 0, 0, 1'b1));
        send_item(pair(POS_INF, ONE, QNAN, 0, 1'b1));
        send_item(pair(MIN_DEN, 64'd0, 0, 0, 1'b0));
        send_item(pair(MAX_FIN, MAX_FIN ^ NEG_ZERO, 0, 0, 1'b1));
        drain();
        cfg_write(CFG_MAX_ABS, 64'hFFFF_FFFF_FFFF_FFFF);
        cfg_write(CFG_MAX_REL, 64'hFFFF_FFFF_FFFF_FFFF);
        cfg_write(2'd3, 64'hFFFF_FFFF_FFFF_FFFF);   // index past the list: drop
        send_item(pair(ONE, TWO, 0, 0, 1'b1));
        send_item(pair(QNAN ^ NEG_ZERO, ONE, 0, 0, 1'b1));
        drain();
    endtask

    // tolerance edges: absolute decides, relative decides, tie on magnitude
    task automatic test_tolerances();
        cfg_write(CFG_MAX_ABS, ONE);
        cfg_write(CFG_MAX_REL, 64'h3FE0_0000_0000_0000);
        send_item(pair(ONE, 64'h3FF8_0000_0000_0000, 0, 0, 1'b0));   // |d| 0.5
        send_item(pair(64'd0, ONE, 0, 0, 1'b0));                      // |d| == tol
        send_item(pair(TWO, 64'h4010_0000_0000_0000, 0, 0, 1'b0));    // rel 0.5, fails
        send_item(pair(TWO, 64'h4008_0000_0000_0000, 0, 0, 1'b1));    // rel 1/3
        send_item(pair(64'h4024_0000_0000_0000, 64'hC024_0000_0000_0000, 0, 0, 1'b1));
        send_item(pair(POS_INF, MAX_FIN, 0, 0, 1'b1));
        drain();
    endtask

    // complex mode: imaginary part counts only after the real part matches
    task automatic test_complex();
        cfg_write(CFG_COMPLEX, 64'd1);
        cfg_write(CFG_MAX_ABS, 64'd0);
        cfg_write(CFG_MAX_REL, 64'd0);
        send_item(pair(ONE, ONE, TWO, TWO, 1'b0));
        send_item(pair(ONE, ONE, TWO, ONE, 1'b0));
        send_item(pair(ONE, TWO, QNAN, QNAN, 1'b1));
        send_item(pair(NEG_ZERO, 64'd0, NEG_INF, NEG_INF, 1'b1));
        drain();
    endtask

    // random arrays under one tolerance setting and one idling profile
    task automatic test_random_phase(int unsigned gp, int unsigned sp, int unsigned count);
        gap_pct = gp;
        stall_pct = sp;
        cfg_write(CFG_MAX_ABS, pick_abs());
        cfg_write(CFG_MAX_REL, pick_rel());
        cfg_write(CFG_COMPLEX, 64'($urandom_range(0, 1)));
        // no input gaps first, then the chosen gaps; stalls apply throughout
        gap_pct = 0;
        repeat (count / 4) send_item(make_pair(12));
        gap_pct = gp;
        repeat (count - count / 4) send_item(make_pair(12));
        drain();
    endtask

    initial begin
        abs_tol = '0; rel_tol = '0; cplx = 1'b0; run_and = 1'b1;
        n_bad = 0; n_sent = 0; n_seen = 0; n_last = 0; n_hits = 0; wdog = 0;
        gap_pct = 0; stall_pct = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_special_operands();
        test_tolerances();
        test_complex();
        for (int p = 0; p < 8; p++) begin
            case (p % 4)
                0: test_random_phase(0, 0, 130);
                1: test_random_phase(51, 0, 130);
                2: test_random_phase(0, 51, 130);
                default: test_random_phase(22, 22, 130);
            endcase
        end

        $display("covered %0d element pairs in %0d arrays, %0d matched", n_sent, n_last,
                 n_hits);
        $display("%0d results checked, %0d mismatches", n_seen, n_bad);
        if (n_bad == 0 && verdicts.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
